@@ rtl/utf8_window_decoder_core_defines.svh @@
// ---------------------------------------------------------------------------
// UTF-8 window decoder assertion macros
// Property wrappers used by the decoder core; they compile away for synthesis.
// ---------------------------------------------------------------------------
`ifndef UTF8_WINDOW_DECODER_CORE_DEFINES_SVH
`define UTF8_WINDOW_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define UTF8WD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("utf8wd assertion failed");
// next-cycle implication
`define UTF8WD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("utf8wd assertion failed");
`else
`define UTF8WD_ASSERT_NOW(label, clk, rstn, ante, cons)
`define UTF8WD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/utf8wd_pkg.sv @@
// ---------------------------------------------------------------------------
// UTF-8 window decoder package
// Request and result types, per-byte lane type and shared constants.
// ---------------------------------------------------------------------------
`default_nettype none

package utf8wd_pkg;

    localparam int unsigned LANE_COUNT = 6;

    localparam logic [2:0]  MODE_INFER     = 3'd0;
    localparam logic [2:0]  MODE_UNDEF     = 3'd7;
    localparam logic [31:0] ERROR_VALUE_RST = 32'd65533;

    typedef struct packed {
        logic [7:0] lead_byte;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [7:0] byte_four;
        logic [7:0] byte_five;
        logic [7:0] byte_six;
        logic [2:0] length_mode;
    } in_t;

    typedef struct packed {
        logic [31:0] code_point;
        logic [2:0]  seq_length;
        logic        is_error;
    } out_t;

    // what one lane finds in one trailing byte of the window
    typedef struct packed {
        logic       cont;
        logic [5:0] payload;
    } lane_t;

endpackage

`default_nettype wire

@@ rtl/utf8wd_lane.sv @@
// ---------------------------------------------------------------------------
// UTF-8 window decoder byte lane
// Classifies one trailing byte: continuation marker and its six payload bits.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8wd_lane (
    input  wire logic [7:0]       byte_in,
    output utf8wd_pkg::lane_t     lane_out
);

    always_comb begin
        lane_out.cont    = (byte_in[7:6] == 2'b10);
        lane_out.payload = byte_in[5:0];
    end

endmodule

`default_nettype wire

@@ rtl/utf8wd_merge.sv @@
// ---------------------------------------------------------------------------
// UTF-8 window decoder merge stage
// Decodes the lead byte, combines the lane flags and packs the code point.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8wd_merge (
    input  wire logic [7:0]          lead_byte,
    input  wire logic [2:0]          length_mode,
    input  wire utf8wd_pkg::lane_t   lanes [utf8wd_pkg::LANE_COUNT],
    input  wire logic [31:0]         error_value,
    output utf8wd_pkg::out_t         result
);

    logic [2:0]  implied;
    logic [2:0]  len_sel;
    logic        bad;
    logic [31:0] cp;

    always_comb begin
        casez (lead_byte)
            8'b0???????: implied = 3'd1;
            8'b110?????: implied = 3'd2;
            8'b1110????: implied = 3'd3;
            8'b11110???: implied = 3'd4;
            8'b111110??: implied = 3'd5;
            8'b1111110?: implied = 3'd6;
            default:     implied = 3'd0;
        endcase
    end

    always_comb begin
        len_sel = (length_mode == utf8wd_pkg::MODE_INFER) ? implied : length_mode;
        bad = (implied == 3'd0) || (length_mode == utf8wd_pkg::MODE_UNDEF) ||
              (len_sel != implied);
        // lane k holds window byte k+1: inside the sequence it must be a
        // continuation, right after a multi-byte sequence it must not be
        for (int k = 0; k < utf8wd_pkg::LANE_COUNT; k++) begin
            if ((3'(k + 1) < implied) && !lanes[k].cont) begin
                bad = 1'b1;
            end
            if ((3'(k + 1) == implied) && (implied >= 3'd2) && lanes[k].cont) begin
                bad = 1'b1;
            end
        end
    end

    always_comb begin
        case (implied)
            3'd1: cp = {25'd0, lead_byte[6:0]};
            3'd2: cp = {21'd0, lead_byte[4:0], lanes[0].payload};
            3'd3: cp = {16'd0, lead_byte[3:0], lanes[0].payload, lanes[1].payload};
            3'd4: cp = {11'd0, lead_byte[2:0], lanes[0].payload, lanes[1].payload,
                        lanes[2].payload};
            3'd5: cp = {6'd0, lead_byte[1:0], lanes[0].payload, lanes[1].payload,
                        lanes[2].payload, lanes[3].payload};
            3'd6: cp = {1'b0, lead_byte[0], lanes[0].payload, lanes[1].payload,
                        lanes[2].payload, lanes[3].payload, lanes[4].payload};
            default: cp = 32'd0;
        endcase
    end

    always_comb begin
        result.code_point = bad ? error_value : cp;
        result.seq_length = implied;
        result.is_error   = bad;
    end

endmodule

`default_nettype wire

@@ rtl/utf8_window_decoder_core.sv @@
// ---------------------------------------------------------------------------
// UTF-8 window decoder core
// Decodes one UTF-8 sequence of up to six bytes from a seven-byte window.
// ---------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry a request: a window that starts at the lead
//   byte plus a length mode (0 infers; 1..6 must equal the implied length).
//   m_valid/m_ready/m_data return one result per request: code point, length
//   implied by the lead byte, error flag; on error the code point is the
//   error value register. cfg_valid/cfg_ready/cfg_data write the error value;
//   cfg_ready is always high. Write it only while no request is in flight.
// Timing:
//   Two stages: byte lanes feed a lane register, the merge logic feeds the
//   output register. A request is held in the lane register and its result
//   in the output register, which m_valid marks; one request per cycle while
//   m_ready stays high. When m_ready is low and a result waits, the output
//   register holds; the lane register takes one more request if empty, then s_ready drops.
// Reset:
//   aresetn (synchronous, active low) empties both stages, error value 0xFFFD.
// ---------------------------------------------------------------------------
`default_nettype none

`include "utf8_window_decoder_core_defines.svh"

module utf8_window_decoder_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire utf8wd_pkg::in_t    s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output utf8wd_pkg::out_t        m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        cfg_data
);

    logic [7:0]         win_bytes [utf8wd_pkg::LANE_COUNT];
    utf8wd_pkg::lane_t  lane_res  [utf8wd_pkg::LANE_COUNT];

    logic               s1_valid_reg, s1_valid_next;
    logic [7:0]         s1_lead_reg;
    logic [2:0]         s1_mode_reg;
    utf8wd_pkg::lane_t  s1_lanes_reg [utf8wd_pkg::LANE_COUNT];

    logic               m_valid_reg, m_valid_next;
    utf8wd_pkg::out_t   m_data_reg;
    utf8wd_pkg::out_t   merge_res;

    logic [31:0]        error_value_reg, error_value_next;
    logic               s1_adv;
    logic               s_fire;

    always_comb begin
        win_bytes[0] = s_data.byte_one;
        win_bytes[1] = s_data.byte_two;
        win_bytes[2] = s_data.byte_three;
        win_bytes[3] = s_data.byte_four;
        win_bytes[4] = s_data.byte_five;
        win_bytes[5] = s_data.byte_six;
    end

    for (genvar g = 0; g < utf8wd_pkg::LANE_COUNT; g++) begin : g_lane
        utf8wd_lane u_lane (
            .byte_in  (win_bytes[g]),
            .lane_out (lane_res[g])
        );
    end

    utf8wd_merge u_merge (
        .lead_byte   (s1_lead_reg),
        .length_mode (s1_mode_reg),
        .lanes       (s1_lanes_reg),
        .error_value (error_value_reg),
        .result      (merge_res)
    );

    // handshake and stage control
    always_comb begin
        s1_adv    = !m_valid_reg || m_ready;
        s_ready   = !s1_valid_reg || s1_adv;
        s_fire    = s_valid && s_ready;
        cfg_ready = 1'b1;

        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        m_valid_next     = s1_adv ? s1_valid_reg : m_valid_reg;
        error_value_next = (cfg_valid && cfg_ready) ? cfg_data : error_value_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            error_value_reg <= utf8wd_pkg::ERROR_VALUE_RST;
        end else begin
            s1_valid_reg    <= s1_valid_next;
            m_valid_reg     <= m_valid_next;
            error_value_reg <= error_value_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_lead_reg  <= s_data.lead_byte;
            s1_mode_reg  <= s_data.length_mode;
            s1_lanes_reg <= lane_res;
        end
        if (s1_adv && s1_valid_reg) begin
            m_data_reg <= merge_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `UTF8WD_ASSERT_NOW(a_err_value, aclk, aresetn, m_valid_reg && m_data_reg.is_error, m_data_reg.code_point == error_value_reg)
    `UTF8WD_ASSERT_NOW(a_bad_lead, aclk, aresetn, m_valid_reg && (m_data_reg.seq_length == 3'd0), m_data_reg.is_error)
    `UTF8WD_ASSERT_NEXT(a_fill, aclk, aresetn, s_valid && s_ready, s1_valid_reg)
    `UTF8WD_ASSERT_NEXT(a_hold, aclk, aresetn, s1_valid_reg && m_valid_reg && !m_ready, s1_valid_reg && m_valid_reg)

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// UTF-8 window decoder testbench
// Sends seven-byte windows through the decoder core and checks every result
// against a decoder written here. The error value register goes through reset,
// both extremes and a random setting. Both sides idle at random until the
// final phase, which runs at full rate.
// ---------------------------------------------------------------------------

module testbench;

    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [1:0]  CONT_TAG     = 2'b10;

    // -----------------------------------------------------------------------
    // expected decode results, kept in request order
    // -----------------------------------------------------------------------
    class utf8_result_tracker;
        utf8wd_pkg::out_t expected_results[$];
        logic [31:0]      error_value = utf8wd_pkg::ERROR_VALUE_RST;
        int unsigned      mismatches  = 0;

        function utf8wd_pkg::out_t decode_window(utf8wd_pkg::in_t req);
            logic [7:0]       win [0:6];
            logic [2:0]       implied;
            logic [2:0]       len;
            logic             ok;
            logic [31:0]      cp;
            utf8wd_pkg::out_t res;
            win = '{req.lead_byte, req.byte_one, req.byte_two, req.byte_three,
                    req.byte_four, req.byte_five, req.byte_six};
            casez (win[0])
                8'b0???????: implied = 3'd1;
                8'b110?????: implied = 3'd2;
                8'b1110????: implied = 3'd3;
                8'b11110???: implied = 3'd4;
                8'b111110??: implied = 3'd5;
                8'b1111110?: implied = 3'd6;
                default:     implied = 3'd0;
            endcase
            len = (req.length_mode == utf8wd_pkg::MODE_INFER) ? implied : req.length_mode;
            ok  = (implied != 3'd0) && (req.length_mode != utf8wd_pkg::MODE_UNDEF) &&
                  (len == implied);
            cp  = '0;
            if (ok) begin
                cp = 32'(win[0] & ((len == 3'd1) ? 8'h7F : (8'h7F >> len)));
                for (int i = 1; i < int'(len); i++) begin
                    if (win[i][7:6] != CONT_TAG) ok = 1'b0;
                    cp = {cp[25:0], win[i][5:0]};
                end
                if (len >= 3'd2 && win[len][7:6] == CONT_TAG) ok = 1'b0;
            end
            res.code_point = ok ? cp : error_value;
            res.seq_length = implied;
            res.is_error   = !ok;
            return res;
        endfunction

        function void note_request(utf8wd_pkg::in_t req);
            expected_results.push_back(decode_window(req));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
            mismatches++;
        endtask

        task check_result(utf8wd_pkg::out_t got);
            utf8wd_pkg::out_t want;
            if (expected_results.size() == 0) begin
                report("unexpected result code_point", got.code_point, '0);
                return;
            end
            want = expected_results.pop_front();
            if (got.code_point !== want.code_point)
                report("code_point", got.code_point, want.code_point);
            if (got.seq_length !== want.seq_length)
                report("seq_length", 32'(got.seq_length), 32'(want.seq_length));
            if (got.is_error !== want.is_error)
                report("is_error", 32'(got.is_error), 32'(want.is_error));
        endtask

        task report_leftovers();
            while (expected_results.size() != 0) begin
                report("missing result code_point", '0, expected_results[0].code_point);
                void'(expected_results.pop_front());
            end
        endtask
    endclass

    // -----------------------------------------------------------------------
    // clock, reset, DUT
    // -----------------------------------------------------------------------
    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    utf8wd_pkg::in_t  s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    utf8wd_pkg::out_t m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [31:0]      cfg_data  = '0;

    int unsigned ready_stall_pct = 0;
    int unsigned stall_cycles    = 0;

    utf8_result_tracker tracker = new();

    initial begin
        forever #5 aclk = ~aclk;
    end

    utf8_window_decoder_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_data);
    end

    // receiver back-pressure in bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (ready_stall_pct != 0 && $urandom_range(0, 99) < ready_stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // -----------------------------------------------------------------------
    // drivers
    // -----------------------------------------------------------------------
    // valid stays high across back-to-back requests; only a gap or a wait for results lowers it
    task automatic send_request(input utf8wd_pkg::in_t req);
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_request(req);
    endtask

    task automatic sender_gap(input int unsigned cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_error_value(input logic [31:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.error_value = value;
    endtask

    // -----------------------------------------------------------------------
    // request generation
    // -----------------------------------------------------------------------
    // well-formed sequence of n bytes with random payload, random tail
    function automatic utf8wd_pkg::in_t make_sequence(int unsigned n, bit forced);
        logic [7:0] win [0:6];
        logic [7:0] lead;
        for (int i = 0; i < 7; i++) win[i] = 8'($urandom);
        lead   = 8'($urandom);
        win[0] = (n == 1) ? {1'b0, lead[6:0]}
                          : ((8'hFF << (8 - n)) | (lead & (8'h7F >> n)));
        for (int i = 1; i < int'(n); i++) win[i] = {CONT_TAG, win[i][5:0]};
        if (n < 7 && win[n][7:6] == CONT_TAG) win[n][6] = 1'b1;
        return {win[0], win[1], win[2], win[3], win[4], win[5], win[6],
                forced ? 3'(n) : utf8wd_pkg::MODE_INFER};
    endfunction

    // one defect in an otherwise good sequence of n bytes
    function automatic utf8wd_pkg::in_t break_sequence(utf8wd_pkg::in_t req,
                                                       int unsigned n);
        logic [55:0] bytes;
        int unsigned pos;
        int unsigned flaw;
        bytes = req[58:3];
        flaw  = (n == 1) ? 0 : $urandom_range(0, 2);
        case (flaw)
            0: req.length_mode = 3'((n % 6) + 1);
            1: begin
                pos = $urandom_range(1, n - 1);
                bytes[55 - 8*pos -: 2] = $urandom_range(0, 1) ? 2'b11 : 2'b00;
                req[58:3] = bytes;
            end
            default: begin
                bytes[55 - 8*n -: 2] = CONT_TAG;
                req[58:3] = bytes;
            end
        endcase
        return req;
    endfunction

    task automatic run_random(input int unsigned count, input int unsigned gap_pct,
                              input bit mid_pause);
        int unsigned     n;
        int unsigned     pick;
        utf8wd_pkg::in_t req;
        for (int unsigned i = 0; i < count; i++) begin
            if (mid_pause && i == count / 2) wait_for_results();
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
                sender_gap($urandom_range(1, 15));
            n    = $urandom_range(1, 6);
            pick = $urandom_range(0, 99);
            req  = make_sequence(n, 1'($urandom_range(0, 1)));
            if (pick >= 85)
                req = utf8wd_pkg::in_t'({32'($urandom), 27'($urandom)});
            else if (pick >= 70)
                req = break_sequence(req, n);
            send_request(req);
        end
    endtask

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    utf8wd_pkg::in_t directed_requests [] = '{
        utf8wd_pkg::in_t'({56'h00_FF_FF_FF_FF_FF_FF, utf8wd_pkg::MODE_INFER}), // smallest
        utf8wd_pkg::in_t'({56'h7F_00_00_00_00_00_00, utf8wd_pkg::MODE_INFER}), // largest one-byte
        utf8wd_pkg::in_t'({56'hC2_A9_00_00_00_00_00, utf8wd_pkg::MODE_INFER}),
        utf8wd_pkg::in_t'({56'hDF_BF_41_00_00_00_00, utf8wd_pkg::MODE_INFER}),
        utf8wd_pkg::in_t'({56'hE2_82_AC_20_00_00_00, utf8wd_pkg::MODE_INFER}),
        // decodes to the reset error value
        utf8wd_pkg::in_t'({56'hEF_BF_BD_00_00_00_00, utf8wd_pkg::MODE_INFER}),
        utf8wd_pkg::in_t'({56'hF4_8F_BF_BF_00_00_00, utf8wd_pkg::MODE_INFER}),
        utf8wd_pkg::in_t'({56'hF7_BF_BF_BF_7F_FF_FF, utf8wd_pkg::MODE_INFER}),
        utf8wd_pkg::in_t'({56'hFB_BF_BF_BF_BF_00_00, utf8wd_pkg::MODE_INFER}),
        // 31-bit maximum
        utf8wd_pkg::in_t'({56'hFD_BF_BF_BF_BF_BF_00, utf8wd_pkg::MODE_INFER}),
        utf8wd_pkg::in_t'({56'hFC_80_80_80_80_80_FF, 3'd6}),
        // bare continuation as lead
        utf8wd_pkg::in_t'({56'h80_80_80_00_00_00_00, utf8wd_pkg::MODE_INFER}),
        utf8wd_pkg::in_t'({56'hFE_80_80_80_80_80_80, utf8wd_pkg::MODE_INFER}),
        utf8wd_pkg::in_t'({56'hFF_BF_BF_BF_BF_BF_BF, 3'd6}),
        utf8wd_pkg::in_t'({56'hBF_00_00_00_00_00_00, 3'd1}),
        // forced length mismatch
        utf8wd_pkg::in_t'({56'hE2_82_AC_00_00_00_00, 3'd2}),
        utf8wd_pkg::in_t'({56'h41_00_00_00_00_00_00, utf8wd_pkg::MODE_UNDEF}),
        utf8wd_pkg::in_t'({56'hE2_82_AC_00_00_00_00, 3'd3}),
        // bad continuation
        utf8wd_pkg::in_t'({56'hE2_41_AC_00_00_00_00, utf8wd_pkg::MODE_INFER}),
        // continuation after the sequence
        utf8wd_pkg::in_t'({56'hC3_A9_80_00_00_00_00, utf8wd_pkg::MODE_INFER}),
        // one byte: trailer not checked
        utf8wd_pkg::in_t'({56'h41_80_80_80_80_80_80, utf8wd_pkg::MODE_INFER}),
        // six-byte with bad terminator
        utf8wd_pkg::in_t'({56'hFD_BF_BF_BF_BF_BF_BF, utf8wd_pkg::MODE_INFER}),
        utf8wd_pkg::in_t'({56'h41_FF_FF_FF_FF_FF_FF, 3'd1}),
        // overlong passes
        utf8wd_pkg::in_t'({56'hC0_80_00_00_00_00_00, utf8wd_pkg::MODE_INFER}),
        // surrogate passes
        utf8wd_pkg::in_t'({56'hED_A0_80_41_00_00_00, utf8wd_pkg::MODE_INFER})
    };

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed windows under the reset error value
        ready_stall_pct = 20;
        foreach (directed_requests[i]) begin
            if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 15));
            send_request(directed_requests[i]);
        end

        write_error_value(32'h0000_0000);
        run_random(500, 20, 1'b1);

        ready_stall_pct = 40;
        write_error_value(32'hFFFF_FFFF);
        run_random(500, 5, 1'b0);

        ready_stall_pct = 10;
        write_error_value($urandom);
        run_random(500, 30, 1'b0);

        // full rate on both sides
        ready_stall_pct = 0;
        write_error_value(utf8wd_pkg::ERROR_VALUE_RST);
        run_random(500, 0, 1'b0);

        wait_for_results();
        tracker.report_leftovers();
        if (tracker.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
